// ===== design/particle_life_scale_color_ramp_unit_assert.svh =====
// Assertion macros shared by the particle life scale and colour ramp RTL.
`ifndef PARTICLE_LIFE_SCALE_COLOR_RAMP_UNIT_ASSERT_SVH
`define PARTICLE_LIFE_SCALE_COLOR_RAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLSCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLSCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/plscr_pkg.sv =====
// Package with constants and the sine table helper for the life ramp unit.
`default_nettype none
package plscr_pkg;

    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [2:0] REG_PEAK_FRACTION = 3'd0;
    localparam logic [2:0] REG_START_SCALE   = 3'd1;
    localparam logic [2:0] REG_PEAK_SCALE    = 3'd2;
    localparam logic [2:0] REG_END_SCALE     = 3'd3;
    localparam logic [2:0] REG_START_COLOR   = 3'd4;
    localparam logic [2:0] REG_PEAK_COLOR    = 3'd5;
    localparam logic [2:0] REG_END_COLOR     = 3'd6;

    // Taylor series divisors (2k)(2k+1) for k from 1 to 13.
    localparam logic [63:0] TAYLOR_DIV [13] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // Sine of a Q2.30 angle, rounded to Q1.16 and clamped to one.
    function automatic logic [16:0] sine_round(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd8192) >> 14;
        if (v > 64'(ONE_Q16)) begin
            v = 64'(ONE_Q16);
        end
        return v[16:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/plscr_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module plscr_div #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_low,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic          r_valid [QW];
    logic [DW-1:0] r_rem   [QW];
    logic [QW-1:0] r_lq    [QW];
    logic [DW-1:0] r_div   [QW];
    logic [SW-1:0] r_side  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          w_pv;
        logic [DW-1:0] w_prem;
        logic [QW-1:0] w_plq;
        logic [DW-1:0] w_pdiv;
        logic [SW-1:0] w_pside;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_lq;

        if (s == 0) begin : g_first
            assign w_pv    = i_valid;
            assign w_prem  = i_rem;
            assign w_plq   = i_low;
            assign w_pdiv  = i_div;
            assign w_pside = i_side;
        end else begin : g_next
            assign w_pv    = r_valid[s-1];
            assign w_prem  = r_rem[s-1];
            assign w_plq   = r_lq[s-1];
            assign w_pdiv  = r_div[s-1];
            assign w_pside = r_side[s-1];
        end

        // The lq word shifts dividend bits out at the top and quotient bits in.
        assign w_trial = {w_prem, w_plq[QW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_pdiv});
        assign w_diff  = w_trial - {1'b0, w_pdiv};
        assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        assign n_lq    = {w_plq[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_lq[s]   <= n_lq;
                r_div[s]  <= w_pdiv;
                r_side[s] <= w_pside;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_lq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ===== design/particle_life_scale_color_ramp_unit.sv =====
// Top level of the particle life scale and colour ramp pipeline.
// The block takes one request per particle (age and lifetime, both in ticks) on a
// valid/ready input channel and returns one request holding the draw scale (signed
// Q8.8) and the four colour channels on a valid/ready output channel.
// The life fraction is formed by a 16-stage divider and the segment progress by a
// 17-stage divider, with one segment selection stage between them; the sine easing
// and the five interpolations take five further stages. That makes 39 register
// stages from the accepted request to o_valid and the registered outputs.
// Throughput is one request per cycle: every stage, both dividers included, moves
// forward together, and a new request may enter on every cycle that o_ready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds in place
// and o_ready falls in the same cycle; nothing is dropped or repeated.
// The configuration registers are written through a plain write port and must only
// be changed while no request is in flight.
// Reset is synchronous and active low: it empties the pipeline and loads the
// register defaults (peak at one quarter of life, scale from 1.0 to 2.0 to 0.0,
// all colours opaque white). The sine table is a constant and needs no fill.
`default_nettype none
module particle_life_scale_color_ramp_unit import plscr_pkg::*; #(
    parameter int SINE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_particle_age,
    input  wire logic [15:0] i_particle_lifetime,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_draw_scale,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

`include "particle_life_scale_color_ramp_unit_assert.svh"

    localparam int IW = $clog2(SINE_ENTRIES + 1);
    localparam int PW = 17 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(SINE_ENTRIES);

    // Configuration registers.
    logic [16:0]        r_peak_fraction;
    logic signed [15:0] r_start_scale;
    logic signed [15:0] r_peak_scale;
    logic signed [15:0] r_end_scale;
    logic [31:0]        r_start_color;
    logic [31:0]        r_peak_color;
    logic [31:0]        r_end_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_fraction <= 17'd16384;
            r_start_scale   <= 16'sd256;
            r_peak_scale    <= 16'sd512;
            r_end_scale     <= 16'sd0;
            r_start_color   <= 32'hFFFF_FFFF;
            r_peak_color    <= 32'hFFFF_FFFF;
            r_end_color     <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PEAK_FRACTION: r_peak_fraction <= i_cfg_data[16:0];
                REG_START_SCALE:   r_start_scale   <= i_cfg_data[15:0];
                REG_PEAK_SCALE:    r_peak_scale    <= i_cfg_data[15:0];
                REG_END_SCALE:     r_end_scale     <= i_cfg_data[15:0];
                REG_START_COLOR:   r_start_color   <= i_cfg_data;
                REG_PEAK_COLOR:    r_peak_color    <= i_cfg_data;
                REG_END_COLOR:     r_end_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // All stages advance together unless a finished result is held back.
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Sine table, built at elaboration and kept non-decreasing.
    logic [16:0] w_raw  [SINE_ENTRIES+1];
    logic [16:0] w_sine [SINE_ENTRIES+1];

    for (genvar i = 0; i <= SINE_ENTRIES; i++) begin : g_sine
        localparam logic [63:0] ANGLE = (64'(i) * HALF_PI_Q30) / SINE_ENTRIES;
        assign w_raw[i] = sine_round(ANGLE);
        if (i == 0) begin : g_first
            assign w_sine[i] = w_raw[i];
        end else begin : g_rest
            assign w_sine[i] = (w_raw[i] < w_sine[i-1]) ? w_sine[i-1] : w_raw[i];
        end
    end

    // Life fraction: age * 65536 / lifetime, saturated at one.
    logic        w_sat;
    logic        w_d1_valid;
    logic [15:0] w_d1_quo;
    logic [0:0]  w_d1_side;

    assign w_sat = (i_particle_lifetime == 16'd0) || (i_particle_age >= i_particle_lifetime);

    plscr_div #(.DW(16), .QW(16), .SW(1)) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_rem   (i_particle_age),
        .i_low   (16'd0),
        .i_div   (i_particle_lifetime),
        .i_side  (w_sat),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    // Segment selection.
    logic [16:0] w_f;
    logic [16:0] w_p;
    logic        w_rise;
    logic [16:0] w_num;
    logic [16:0] w_den;

    assign w_f    = w_d1_side[0] ? ONE_Q16 : {1'b0, w_d1_quo};
    assign w_p    = (r_peak_fraction > ONE_Q16) ? ONE_Q16 : r_peak_fraction;
    assign w_rise = (w_f < w_p);
    assign w_num  = w_rise ? w_f : (w_f - w_p);
    assign w_den  = w_rise ? w_p : (ONE_Q16 - w_p);

    logic        r_a_valid;
    logic [16:0] r_a_num;
    logic [16:0] r_a_den;
    logic        r_a_rise;
    logic        r_a_force;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_num   <= w_num;
            r_a_den   <= w_den;
            r_a_rise  <= w_rise;
            r_a_force <= !w_rise && (w_den == 17'd0);
        end
    end

    // Segment progress: num * 65536 / den, quotient at most one.
    logic        w_d2_valid;
    logic [16:0] w_d2_quo;
    logic [1:0]  w_d2_side;

    plscr_div #(.DW(17), .QW(17), .SW(2)) u_prog_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_valid),
        .i_rem   ({1'b0, r_a_num[16:1]}),
        .i_low   ({r_a_num[0], 16'd0}),
        .i_div   (r_a_den),
        .i_side  ({r_a_rise, r_a_force}),
        .o_valid (w_d2_valid),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    // Table position.
    logic [16:0]   w_u;
    logic [PW-1:0] w_pos;

    assign w_u   = w_d2_side[0] ? ONE_Q16 : w_d2_quo;
    assign w_pos = PW'(w_u) * PW'(SINE_ENTRIES);

    logic          r_b_valid;
    logic [IW-1:0] r_b_idx;
    logic [15:0]   r_b_fr;
    logic          r_b_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_idx  <= w_pos[16+IW-1:16];
            r_b_fr   <= w_pos[15:0];
            r_b_rise <= w_d2_side[1];
        end
    end

    // Table lookup of the two neighbouring entries.
    logic          w_top;
    logic [IW-1:0] w_idx_hi;
    logic [16:0]   w_lo;
    logic [16:0]   w_hi;

    assign w_top    = (r_b_idx >= LAST_IDX);
    assign w_idx_hi = w_top ? LAST_IDX : (r_b_idx + 1'b1);
    assign w_lo     = w_top ? w_sine[LAST_IDX] : w_sine[r_b_idx];
    assign w_hi     = w_sine[w_idx_hi];

    logic        r_c_valid;
    logic [16:0] r_c_lo;
    logic [16:0] r_c_diff;
    logic [15:0] r_c_fr;
    logic        r_c_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_lo   <= w_lo;
            r_c_diff <= w_top ? 17'd0 : (w_hi - w_lo);
            r_c_fr   <= r_b_fr;
            r_c_rise <= r_b_rise;
        end
    end

    // Easing weight by linear interpolation between table entries.
    logic [32:0] w_step;
    assign w_step = 33'(r_c_diff) * 33'(r_c_fr);

    logic        r_d_valid;
    logic [16:0] r_d_t;
    logic        r_d_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_t    <= r_c_lo + w_step[32:16];
            r_d_rise <= r_c_rise;
        end
    end

    // Products of the weight with the endpoint differences.
    logic signed [15:0] w_ea;
    logic signed [15:0] w_eb;
    logic signed [16:0] w_ds;
    logic signed [17:0] w_t_s;
    logic [31:0]        w_eca;
    logic [31:0]        w_ecb;

    assign w_ea  = r_d_rise ? r_start_scale : r_peak_scale;
    assign w_eb  = r_d_rise ? r_peak_scale : r_end_scale;
    assign w_ds  = {w_eb[15], w_eb} - {w_ea[15], w_ea};
    assign w_t_s = $signed({1'b0, r_d_t});
    assign w_eca = r_d_rise ? r_start_color : r_peak_color;
    assign w_ecb = r_d_rise ? r_peak_color : r_end_color;

    logic               r_e_valid;
    logic signed [34:0] r_e_prod_s;
    logic signed [26:0] r_e_prod_c [4];
    logic               r_e_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_prod_s <= w_ds * w_t_s;
            r_e_rise   <= r_d_rise;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_chan_mul
        logic signed [8:0] w_dc;
        assign w_dc = $signed({1'b0, w_ecb[8*c +: 8]}) - $signed({1'b0, w_eca[8*c +: 8]});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_e_prod_c[c] <= w_dc * w_t_s;
            end
        end
    end

    // Final sums: the arithmetic shift floors toward minus infinity.
    logic signed [15:0] w_fa;
    logic [31:0]        w_fca;
    logic [18:0]        w_sum_s;
    logic [7:0]         w_chan [4];

    assign w_fa    = r_e_rise ? r_start_scale : r_peak_scale;
    assign w_fca   = r_e_rise ? r_start_color : r_peak_color;
    assign w_sum_s = {{3{w_fa[15]}}, w_fa} + r_e_prod_s[34:16];

    for (genvar c = 0; c < 4; c++) begin : g_chan_sum
        logic [10:0] w_sum_c;
        assign w_sum_c   = {3'b000, w_fca[8*c +: 8]} + r_e_prod_c[c][26:16];
        assign w_chan[c] = w_sum_c[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_draw_scale <= w_sum_s[15:0];
            o_red        <= w_chan[0];
            o_green      <= w_chan[1];
            o_blue       <= w_chan[2];
            o_alpha      <= w_chan[3];
        end
    end

    // The easing weight never exceeds one.
    `PLSCR_ASSERT_NOW(a_weight_max, r_d_valid, r_d_t <= ONE_Q16, "easing weight above one")
    // A zero falling span only arises in the falling segment.
    `PLSCR_ASSERT_NOW(a_force_fall, r_a_valid && r_a_force, !r_a_rise, "forced progress while rising")
    // A stall freezes the divider outputs.
    `PLSCR_ASSERT_NEXT(a_stall_hold, !w_en, $stable(w_d2_valid) && $stable(w_d1_valid), "pipeline moved during stall")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the particle life scale and colour ramp unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import plscr_pkg::*;

    localparam int SINE_N = 256;
    localparam int LATENCY = 39;

    typedef struct packed {
        logic [15:0] age;
        logic [15:0] life;
    } t_particle;

    typedef struct packed {
        logic [15:0] scale;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_appearance;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_particle_age = '0;
    logic [15:0] i_particle_lifetime = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_draw_scale;
    logic [7:0]  o_red, o_green, o_blue, o_alpha;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    particle_life_scale_color_ramp_unit #(.SINE_ENTRIES(SINE_N)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor copy of the registers and the easing table.
    logic [16:0] peak_reg;
    logic [15:0] start_sc, peak_sc, end_sc;
    logic [31:0] start_col, peak_col, end_col;
    longint      ease_table [SINE_N+1];

    t_particle   pending_particles [$];
    t_appearance expected_looks [$];
    int          fail_count = 0;
    bit          hold_request = 1'b0;  // asks the receiver for its long hold-off
    bit          hold_started = 1'b0;
    int          hold_off = 0;         // long receiver hold-off, counted in cycles

    // Builds the Q1.16 sine table from a Q2.30 Taylor series.
    function automatic void fill_ease_table();
        longint unsigned x, x2, term, total, v;
        for (int i = 0; i <= SINE_N; i++) begin
            x = (longint'(i) * 64'd1686629713) / SINE_N;
            x2 = (x * x) >> 30;
            term = x;
            total = x;
            for (int k = 1; k <= 13; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) total = (total >= term) ? total - term : 0;
                else total = total + term;
            end
            v = (total + 8192) >> 14;
            if (v > 65536) v = 65536;
            if (i > 0 && v < ease_table[i-1]) v = ease_table[i-1];
            ease_table[i] = v;
        end
    endfunction

    // Linear blend with the quotient floored towards minus infinity.
    function automatic longint blend(longint a, longint b, longint t);
        longint prod;
        longint q;
        prod = (b - a) * t;
        if (prod >= 0) q = prod >>> 16;
        else q = -((-prod + 65535) >>> 16);
        return a + q;
    endfunction

    function automatic t_appearance predict_look(t_particle pt);
        longint p, f, u, t, pos, idx, fr, sa, sb;
        logic [31:0] ca, cb;
        t_appearance r;
        p = (peak_reg > 17'h10000) ? 65536 : peak_reg;
        if (pt.life == 0 || pt.age >= pt.life) f = 65536;
        else f = (longint'(pt.age) << 16) / pt.life;
        if (f < p) begin
            u = (f << 16) / p;
            sa = longint'($signed(start_sc)); sb = longint'($signed(peak_sc));
            ca = start_col; cb = peak_col;
        end else begin
            u = (p == 65536) ? 65536 : ((f - p) << 16) / (65536 - p);
            sa = longint'($signed(peak_sc)); sb = longint'($signed(end_sc));
            ca = peak_col; cb = end_col;
        end
        pos = u * SINE_N;
        idx = pos >> 16;
        fr = pos & 16'hFFFF;
        if (idx >= SINE_N) t = ease_table[SINE_N];
        else t = ease_table[idx] + (((ease_table[idx+1] - ease_table[idx]) * fr) >> 16);
        r.scale = 16'(blend(sa, sb, t));
        r.red   = 8'(blend(ca[7:0],   cb[7:0],   t));
        r.green = 8'(blend(ca[15:8],  cb[15:8],  t));
        r.blue  = 8'(blend(ca[23:16], cb[23:16], t));
        r.alpha = 8'(blend(ca[31:24], cb[31:24], t));
        return r;
    endfunction

    // Appends one particle to the tail of the pending queue.
    function automatic void add_particle(logic [15:0] age, logic [15:0] life);
        t_particle pt;
        pt.age = age;
        pt.life = life;
        pending_particles.insert(pending_particles.size(), pt);
    endfunction

    // Register write; the predictor copy is updated alongside the block.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PEAK_FRACTION: peak_reg = value[16:0];
            REG_START_SCALE:   start_sc = value[15:0];
            REG_PEAK_SCALE:    peak_sc = value[15:0];
            REG_END_SCALE:     end_sc = value[15:0];
            REG_START_COLOR:   start_col = value;
            REG_PEAK_COLOR:    peak_col = value;
            REG_END_COLOR:     end_col = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request has gone through and the pipeline is empty.
    task automatic drain();
        while (pending_particles.size() != 0 || i_valid || expected_looks.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_tick();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        t_particle pt;
        for (int i = 0; i < n; i++) begin
            pt.life = random_tick();
            // Mostly live particles, with age within the lifetime.
            if ($urandom_range(0, 4) != 0 && pt.life != 0)
                pt.age = 16'($urandom_range(0, pt.life - 1));
            else
                pt.age = random_tick();
            add_particle(pt.age, pt.life);
        end
    endtask

    // Driver: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_particles.size() != 0) begin
                    t_particle pt;
                    pt = pending_particles.pop_front();
                    expected_looks.insert(expected_looks.size(), predict_look(pt));
                    i_particle_age <= pt.age;
                    i_particle_lifetime <= pt.life;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a pattern of its own, plus the long hold-off.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_off <= 150;
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (stall_phase[8]) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: each accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_looks.size() == 0) begin
                $display("%0t: unexpected result scale=%h", $time, o_draw_scale);
                fail_count <= fail_count + 1;
            end else begin
                t_appearance e;
                t_appearance a;
                e = expected_looks.pop_front();
                a = '{o_draw_scale, o_red, o_green, o_blue, o_alpha};
                if (a !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, a);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    initial begin
        fill_ease_table();
        peak_reg = 17'd16384;
        start_sc = 16'd256; peak_sc = 16'd512; end_sc = 16'd0;
        start_col = '1; peak_col = '1; end_col = '1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed particles under the reset defaults: zero lifetime, age past
        // the end, the exact peak and the field extremes.
        add_particle(16'd0, 16'd0);
        add_particle(16'hFFFF, 16'd0);
        add_particle(16'd0, 16'hFFFF);
        add_particle(16'hFFFF, 16'hFFFF);
        add_particle(16'hFFFE, 16'hFFFF);
        add_particle(16'd1, 16'd4);
        add_particle(16'd5, 16'd4);
        add_particle(16'h5555, 16'hAAAA);
        add_particle(16'd3, 16'd7);
        drain();

        // Extreme scales and contrasting colours; a peak value beyond one.
        write_reg(REG_START_SCALE, 32'h0000_8000);
        write_reg(REG_PEAK_SCALE, 32'hFFFF_7FFF);
        write_reg(REG_END_SCALE, 32'h0000_8000);
        write_reg(REG_START_COLOR, 32'h00FF_00FF);
        write_reg(REG_PEAK_COLOR, 32'hFF00_FF00);
        write_reg(REG_END_COLOR, 32'h0000_0000);
        write_reg(REG_PEAK_FRACTION, 32'h0001_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        add_particle(16'd0, 16'd0);
        add_particle(16'd100, 16'd200);
        add_particle(16'hFFFF, 16'hFFFF);
        queue_random(5);
        drain();

        // Peak at one and peak at zero.
        write_reg(REG_PEAK_FRACTION, 32'h0001_0000);
        queue_random(5);
        add_particle(16'd0, 16'd0);
        drain();
        write_reg(REG_PEAK_FRACTION, 32'd0);
        queue_random(5);
        drain();

        // Random phases with random settings; the first one carries the long
        // receiver hold-off so that the pipeline fills and stalls its input.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_PEAK_FRACTION, ($urandom_range(0, 3) == 0) ?
                      32'($urandom_range(65530, 65536)) : 32'($urandom_range(1, 65535)));
            write_reg(REG_START_SCALE, $urandom);
            write_reg(REG_PEAK_SCALE, $urandom);
            write_reg(REG_END_SCALE, $urandom);
            write_reg(REG_START_COLOR, $urandom);
            write_reg(REG_PEAK_COLOR, $urandom);
            write_reg(REG_END_COLOR, $urandom);
            queue_random(105);
            if (ph == 0) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            drain();
        end

        if (fail_count == 0 && expected_looks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
